FILE: sv/ece_pkg.sv
`default_nettype none

package ece_pkg;

  // fixed-point layout
  localparam int FRAC_BITS = 16;
  localparam int IB        = 28;
  localparam int SH        = IB - FRAC_BITS;
  localparam int PH_W      = FRAC_BITS + 1;
  localparam int OUT_W     = FRAC_BITS + 2;
  localparam int FUNC_W    = 4;
  localparam int A_W       = IB + 2;
  localparam int B_W       = IB + 6;
  localparam int ACC_W     = IB + 10;
  localparam int IN_DW     = ((PH_W + 7) / 8) * 8;
  localparam int OUT_DW    = ((OUT_W + 7) / 8) * 8;

  typedef logic signed [A_W-1:0]   a_t;
  typedef logic signed [B_W-1:0]   b_t;
  typedef logic signed [ACC_W-1:0] q_t;
  typedef logic [PH_W-1:0]         ph_t;

  localparam ph_t ONE_P = {1'b1, {FRAC_BITS{1'b0}}};

  // rounding half for a Q.IB product
  localparam logic [A_W+B_W-1:0] PROD_HALF = (A_W + B_W)'(64'd1 << (IB - 1));

  // Q.IB constants, rounded to nearest
  localparam q_t UNIT    = q_t'(64'd1 << IB);
  localparam q_t K_QGAIN = q_t'(((64'd25 << IB) + 64'd8) / 64'd16);
  localparam q_t K_QTOP  = q_t'(((64'd9 << IB) + 64'd4) / 64'd8);
  localparam q_t K_QCURV = q_t'(((64'd25 << IB) + 64'd1) / 64'd2);
  localparam q_t K_CGAIN = q_t'(((64'd1953 << IB) + 64'd500) / 64'd1000);
  localparam q_t K_CTOP  = q_t'(((64'd19 << IB) + 64'd8) / 64'd16);
  localparam q_t K_CCURV = q_t'(((64'd75 << IB) + 64'd2) / 64'd4);
  localparam q_t K_RGAIN = q_t'(((64'd24414 << IB) + 64'd5000) / 64'd10000);
  localparam q_t K_MGAIN = q_t'(((64'd18519 << IB) + 64'd500) / 64'd1000);
  localparam q_t K_25    = q_t'(64'd25 << IB);
  localparam q_t K_125   = q_t'(((64'd5 << IB) + 64'd2) / 64'd4);
  localparam q_t K_0P9   = q_t'(((64'd9 << IB) + 64'd5) / 64'd10);
  localparam q_t K_0P1   = q_t'(((64'd1 << IB) + 64'd5) / 64'd10);
  localparam q_t K_HALF  = q_t'(64'd1 << (IB - 1));
  localparam q_t K_QTR   = q_t'(64'd1 << (IB - 2));
  localparam q_t K_N1    = q_t'(((64'd121 << IB) + 64'd8) / 64'd16);
  localparam q_t K_OFF1  = q_t'(((64'd6 << IB) + 64'd5) / 64'd11);
  localparam q_t K_OFF2  = q_t'(((64'd9 << IB) + 64'd5) / 64'd11);
  localparam q_t K_OFF3  = q_t'(((64'd21 << IB) + 64'd11) / 64'd22);
  localparam q_t K_LIFT1 = q_t'(((64'd3 << IB) + 64'd2) / 64'd4);
  localparam q_t K_LIFT2 = q_t'(((64'd15 << IB) + 64'd8) / 64'd16);
  localparam q_t K_LIFT3 = q_t'(((64'd63 << IB) + 64'd32) / 64'd64);

  // curve selector codes
  typedef enum logic [FUNC_W-1:0] {
    F_QUAD_IN, F_QUAD_OUT, F_QUAD_INOUT, F_QUAD_PUMP,
    F_CUBE_IN, F_CUBE_OUT, F_CUBE_INOUT, F_CUBE_PUMP, F_CUBE_PUMP_INOUT,
    F_QUART_IN, F_QUART_OUT, F_QUART_INOUT, F_QUART_PUMP,
    F_BOUNCE_IN, F_BOUNCE_OUT, F_BOUNCE_INOUT
  } func_t;

  // second multiplier operand
  typedef enum logic [1:0] {
    B2_UNIT, B2_OPND, B2_SQR
  } b2_sel_t;

  // per-item multiply/combine plan: v = base +/- ((opnd^2 * b2 * b3) << scl)
  typedef struct packed {
    a_t         opnd;
    b2_sel_t    b2_sel;
    b_t         b3;
    q_t         base;
    logic       sub;
    logic [1:0] scl;
    logic       extra;
  } dec_t;

endpackage

`default_nettype wire

FILE: sv/easing_curve_evaluator_unit.sv
`default_nettype none

// Easing curve evaluator: takes a curve selector on in_tuser and an unsigned Q1.16 phase on
// in_tdata (values above 1.0 are saturated to 1.0) and returns the eased value as signed
// Q2.16, rounded to nearest, on out_tdata. It holds no state. The datapath is a six-stage
// pipeline (decode, three chained rounded multiplies, combine, round and saturate), so
// one item is accepted every clock while the output is not stalled; a result is offered on
// out_tvalid from the round-and-saturate register once it has passed through every stage,
// and every stage has its own valid bit and a stalled output only blocks stages that are
// full, so bubbles are squeezed out.
module easing_curve_evaluator_unit (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        in_tvalid,
  output logic                       in_tready,
  input  wire [ece_pkg::IN_DW-1:0]   in_tdata,   // phase
  input  wire [ece_pkg::FUNC_W-1:0]  in_tuser,   // func
  output logic                       out_tvalid,
  input  wire                        out_tready,
  output logic [ece_pkg::OUT_DW-1:0] out_tdata   // eased_value
);

  localparam int NST = 6;

  logic [NST-1:0] vld_r;
  logic [NST-1:0] vld_nxt;
  logic [NST-1:0] rdy;

  ece_pkg::dec_t dec_nxt;
  ece_pkg::dec_t s1_dec_r;
  ece_pkg::dec_t s2_dec_r;
  ece_pkg::dec_t s3_dec_r;
  ece_pkg::dec_t s4_dec_r;
  ece_pkg::b_t   m1_nxt;
  ece_pkg::b_t   m1_r;
  ece_pkg::b_t   b2;
  ece_pkg::b_t   m2_nxt;
  ece_pkg::b_t   m2_r;
  ece_pkg::b_t   m3_nxt;
  ece_pkg::b_t   m3_r;
  ece_pkg::q_t   term;
  ece_pkg::q_t   v_nxt;
  ece_pkg::q_t   v_r;
  logic          ext_r;
  logic [ece_pkg::ACC_W-1:0] mag;
  logic [ece_pkg::ACC_W-1:0] rsum;
  logic [ece_pkg::ACC_W-1:0] rmag;
  logic [ece_pkg::OUT_W-1:0] res_nxt;
  logic [ece_pkg::OUT_W-1:0] res_r;

  // per-stage ready: a stage loads when empty or when its successor moves on
  always_comb begin
    rdy[NST-1] = !vld_r[NST-1] || out_tready;
    for (int k = NST - 2; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  assign in_tready  = rdy[0];
  assign out_tvalid = vld_r[NST-1];
  assign out_tdata  = {{(ece_pkg::OUT_DW - ece_pkg::OUT_W){1'b0}}, res_r};

  always_comb begin
    vld_nxt[0] = rdy[0] ? in_tvalid : vld_r[0];
    for (int k = 1; k < NST; k++) begin
      vld_nxt[k] = rdy[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  // decode
  ece_decode u_decode (
    .func_i  (in_tuser),
    .phase_i (in_tdata[ece_pkg::PH_W-1:0]),
    .dec_o   (dec_nxt)
  );

  // first multiply: operand squared
  ece_fmul u_mul1 (
    .a_i (s1_dec_r.opnd),
    .b_i (ece_pkg::b_t'(s1_dec_r.opnd)),
    .p_o (m1_nxt)
  );

  // second multiply: by unity, operand or the square itself
  always_comb begin
    case (s2_dec_r.b2_sel)
      ece_pkg::B2_OPND: b2 = ece_pkg::b_t'(s2_dec_r.opnd);
      ece_pkg::B2_SQR:  b2 = m1_r;
      default:          b2 = ece_pkg::b_t'(ece_pkg::UNIT);
    endcase
  end

  ece_fmul u_mul2 (
    .a_i (ece_pkg::a_t'(m1_r)),
    .b_i (b2),
    .p_o (m2_nxt)
  );

  // third multiply: curve gain
  ece_fmul u_mul3 (
    .a_i (ece_pkg::a_t'(m2_r)),
    .b_i (s3_dec_r.b3),
    .p_o (m3_nxt)
  );

  // combine with the base constant
  always_comb begin
    term  = ece_pkg::q_t'(m3_r) <<< s4_dec_r.scl;
    v_nxt = s4_dec_r.sub ? s4_dec_r.base - term : s4_dec_r.base + term;
  end

  // round to Q2.FRAC_BITS and saturate
  always_comb begin
    mag = v_r[ece_pkg::ACC_W-1] ? {ece_pkg::ACC_W{1'b0}} - v_r : v_r;
    if (ext_r) begin
      rsum = mag + (ece_pkg::ACC_W'(1) << ece_pkg::SH);
      rmag = rsum >> (ece_pkg::SH + 1);
    end else begin
      rsum = mag + (ece_pkg::ACC_W'(1) << (ece_pkg::SH - 1));
      rmag = rsum >> ece_pkg::SH;
    end
    if (v_r[ece_pkg::ACC_W-1]) begin
      if (rmag > (ece_pkg::ACC_W'(1) << (ece_pkg::OUT_W - 1))) begin
        res_nxt = {1'b1, {(ece_pkg::OUT_W - 1){1'b0}}};
      end else begin
        res_nxt = {ece_pkg::OUT_W{1'b0}} - rmag[ece_pkg::OUT_W-1:0];
      end
    end else begin
      if (rmag > ((ece_pkg::ACC_W'(1) << (ece_pkg::OUT_W - 1)) - ece_pkg::ACC_W'(1))) begin
        res_nxt = {1'b0, {(ece_pkg::OUT_W - 1){1'b1}}};
      end else begin
        res_nxt = rmag[ece_pkg::OUT_W-1:0];
      end
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      s1_dec_r <= dec_nxt;
    end
    if (rdy[1]) begin
      s2_dec_r <= s1_dec_r;
      m1_r     <= m1_nxt;
    end
    if (rdy[2]) begin
      s3_dec_r <= s2_dec_r;
      m2_r     <= m2_nxt;
    end
    if (rdy[3]) begin
      s4_dec_r <= s3_dec_r;
      m3_r     <= m3_nxt;
    end
    if (rdy[4]) begin
      v_r   <= v_nxt;
      ext_r <= s4_dec_r.extra;
    end
    if (rdy[5]) begin
      res_r <= res_nxt;
    end
  end

  // an input transfer always lands in the first stage
  a_in_lands : assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> vld_r[0])
    else $error("input transfer not captured");

  // a blocked stage keeps its item
  a_stall_hold : assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[2] && !rdy[2] |=> vld_r[2])
    else $error("stalled stage lost its item");

  // an empty output stage never holds back the input
  a_no_false_stall : assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled while output empty");

  // an item in the second-to-last stage reaches the output while the output drains
  a_out_refill : assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[NST-2] && out_tready |=> out_tvalid)
    else $error("result dropped on the way to the output");

endmodule

`default_nettype wire

FILE: sv/ece_fmul.sv
`default_nettype none

// sign-magnitude Q.IB multiply, rounded half away from zero
module ece_fmul (
  input  wire ece_pkg::a_t a_i,
  input  wire ece_pkg::b_t b_i,
  output ece_pkg::b_t      p_o
);

  logic [ece_pkg::A_W-1:0]             mag_a;
  logic [ece_pkg::B_W-1:0]             mag_b;
  logic [ece_pkg::A_W+ece_pkg::B_W-1:0] prod;
  logic [ece_pkg::A_W+ece_pkg::B_W-1:0] rnd;
  logic [ece_pkg::B_W-1:0]             mag_p;
  logic                                neg;

  // magnitudes and sign
  assign mag_a = a_i[ece_pkg::A_W-1] ? {ece_pkg::A_W{1'b0}} - a_i : a_i;
  assign mag_b = b_i[ece_pkg::B_W-1] ? {ece_pkg::B_W{1'b0}} - b_i : b_i;
  assign neg   = a_i[ece_pkg::A_W-1] ^ b_i[ece_pkg::B_W-1];

  // full product, round, drop fraction
  assign prod  = {{ece_pkg::B_W{1'b0}}, mag_a} * {{ece_pkg::A_W{1'b0}}, mag_b};
  assign rnd   = prod + ece_pkg::PROD_HALF;
  assign mag_p = rnd[ece_pkg::IB +: ece_pkg::B_W];

  assign p_o = neg ? {ece_pkg::B_W{1'b0}} - mag_p : mag_p;

endmodule

`default_nettype wire

FILE: sv/ece_decode.sv
`default_nettype none

// phase saturation, branch selection and operand setup for one item
module ece_decode (
  input  wire [ece_pkg::FUNC_W-1:0] func_i,
  input  wire ece_pkg::ph_t         phase_i,
  output ece_pkg::dec_t             dec_o
);

  ece_pkg::ph_t         p;
  ece_pkg::a_t          x;
  ece_pkg::a_t          r;
  ece_pkg::a_t          n09;
  ece_pkg::a_t          n01;
  ece_pkg::a_t          n05;
  ece_pkg::a_t          bnc;
  ece_pkg::q_t          lift;
  ece_pkg::q_t          off;
  ece_pkg::ph_t         u;
  logic [ece_pkg::PH_W:0]   p2;
  logic [ece_pkg::PH_W:0]   one2;
  logic [ece_pkg::PH_W+2:0] p5;
  logic [ece_pkg::PH_W+2:0] one5;
  logic [ece_pkg::PH_W+3:0] u11;
  logic [ece_pkg::PH_W+3:0] one11;
  logic                 low_half;
  logic                 upto8;
  logic                 le02;
  logic                 ge08;
  ece_pkg::func_t       fsel;

  assign fsel = ece_pkg::func_t'(func_i);

  // saturate phase and form the Q.IB operands
  always_comb begin
    p   = (phase_i > ece_pkg::ONE_P) ? ece_pkg::ONE_P : phase_i;
    x   = ece_pkg::a_t'({1'b0, p, {ece_pkg::SH{1'b0}}});
    r   = ece_pkg::a_t'(ece_pkg::UNIT) - x;
    n09 = ece_pkg::a_t'(ece_pkg::K_0P9) - x;
    n01 = ece_pkg::a_t'(ece_pkg::K_0P1) - x;
    n05 = ece_pkg::a_t'(ece_pkg::K_HALF) - x;
  end

  // exact threshold compares on the integer phase
  always_comb begin
    p2       = {p, 1'b0};
    one2     = {1'b0, ece_pkg::ONE_P};
    p5       = ({3'b000, p} << 2) + {3'b000, p};
    one5     = {3'b000, ece_pkg::ONE_P};
    low_half = p2 < one2;
    upto8    = p5 <= (one5 << 2);
    le02     = p5 <= one5;
    ge08     = p5 >= (one5 << 2);
  end

  // bounce argument and parabola segment
  always_comb begin
    case (fsel)
      ece_pkg::F_BOUNCE_IN:  u = ece_pkg::ONE_P - p;
      ece_pkg::F_BOUNCE_OUT: u = p;
      default: begin
        if (low_half) begin
          u = ece_pkg::ph_t'(one2 - p2);
        end else begin
          u = ece_pkg::ph_t'(p2 - one2);
        end
      end
    endcase
    u11   = ({4'b0000, u} << 3) + ({4'b0000, u} << 1) + {4'b0000, u};
    one11 = {4'b0000, ece_pkg::ONE_P};
    if (u11 < (one11 << 2)) begin
      off  = '0;
      lift = '0;
    end else if (u11 < (one11 << 3)) begin
      off  = ece_pkg::K_OFF1;
      lift = ece_pkg::K_LIFT1;
    end else if (u11 < ((one11 << 3) + (one11 << 1))) begin
      off  = ece_pkg::K_OFF2;
      lift = ece_pkg::K_LIFT2;
    end else begin
      off  = ece_pkg::K_OFF3;
      lift = ece_pkg::K_LIFT3;
    end
    bnc = ece_pkg::a_t'({1'b0, u, {ece_pkg::SH{1'b0}}}) - ece_pkg::a_t'(off);
  end

  // per-curve plan
  always_comb begin
    dec_o.opnd   = x;
    dec_o.b2_sel = ece_pkg::B2_UNIT;
    dec_o.b3     = ece_pkg::b_t'(ece_pkg::UNIT);
    dec_o.base   = '0;
    dec_o.sub    = 1'b0;
    dec_o.scl    = 2'd0;
    dec_o.extra  = 1'b0;
    case (fsel)
      ece_pkg::F_QUAD_IN: begin
      end
      ece_pkg::F_QUAD_OUT: begin
        dec_o.opnd = r;
        dec_o.base = ece_pkg::UNIT;
        dec_o.sub  = 1'b1;
      end
      ece_pkg::F_QUAD_INOUT: begin
        dec_o.scl = 2'd1;
        if (!low_half) begin
          dec_o.opnd = r;
          dec_o.base = ece_pkg::UNIT;
          dec_o.sub  = 1'b1;
        end
      end
      ece_pkg::F_QUAD_PUMP: begin
        if (upto8) begin
          dec_o.b3 = ece_pkg::b_t'(ece_pkg::K_QGAIN);
        end else begin
          dec_o.opnd = n09;
          dec_o.b3   = ece_pkg::b_t'(ece_pkg::K_QCURV);
          dec_o.base = ece_pkg::K_QTOP;
          dec_o.sub  = 1'b1;
        end
      end
      ece_pkg::F_CUBE_IN: begin
        dec_o.b2_sel = ece_pkg::B2_OPND;
      end
      ece_pkg::F_CUBE_OUT: begin
        dec_o.b2_sel = ece_pkg::B2_OPND;
        dec_o.opnd   = r;
        dec_o.base   = ece_pkg::UNIT;
        dec_o.sub    = 1'b1;
      end
      ece_pkg::F_CUBE_INOUT: begin
        dec_o.b2_sel = ece_pkg::B2_OPND;
        dec_o.scl    = 2'd2;
        if (!low_half) begin
          dec_o.opnd = r;
          dec_o.base = ece_pkg::UNIT;
          dec_o.sub  = 1'b1;
        end
      end
      ece_pkg::F_CUBE_PUMP: begin
        if (upto8) begin
          dec_o.b2_sel = ece_pkg::B2_OPND;
          dec_o.b3     = ece_pkg::b_t'(ece_pkg::K_CGAIN);
        end else begin
          dec_o.opnd = n09;
          dec_o.b3   = ece_pkg::b_t'(ece_pkg::K_CCURV);
          dec_o.base = ece_pkg::K_CTOP;
          dec_o.sub  = 1'b1;
        end
      end
      ece_pkg::F_CUBE_PUMP_INOUT: begin
        if (le02) begin
          dec_o.opnd = n01;
          dec_o.b3   = ece_pkg::b_t'(ece_pkg::K_25);
          dec_o.base = '0 - ece_pkg::K_QTR;
        end else if (ge08) begin
          dec_o.opnd = n09;
          dec_o.b3   = ece_pkg::b_t'(ece_pkg::K_25);
          dec_o.base = ece_pkg::K_125;
          dec_o.sub  = 1'b1;
        end else begin
          dec_o.opnd   = n05;
          dec_o.b2_sel = ece_pkg::B2_OPND;
          dec_o.b3     = ece_pkg::b_t'(ece_pkg::K_MGAIN);
          dec_o.base   = ece_pkg::K_HALF;
          dec_o.sub    = 1'b1;
        end
      end
      ece_pkg::F_QUART_IN: begin
        dec_o.b2_sel = ece_pkg::B2_SQR;
      end
      ece_pkg::F_QUART_OUT: begin
        dec_o.b2_sel = ece_pkg::B2_SQR;
        dec_o.opnd   = r;
        dec_o.base   = ece_pkg::UNIT;
        dec_o.sub    = 1'b1;
      end
      ece_pkg::F_QUART_INOUT: begin
        dec_o.b2_sel = ece_pkg::B2_SQR;
        dec_o.scl    = 2'd3;
        if (!low_half) begin
          dec_o.opnd = r;
          dec_o.base = ece_pkg::UNIT;
          dec_o.sub  = 1'b1;
        end
      end
      ece_pkg::F_QUART_PUMP: begin
        if (upto8) begin
          dec_o.b2_sel = ece_pkg::B2_SQR;
          dec_o.b3     = ece_pkg::b_t'(ece_pkg::K_RGAIN);
        end else begin
          dec_o.opnd = n09;
          dec_o.b3   = ece_pkg::b_t'(ece_pkg::K_25);
          dec_o.base = ece_pkg::K_125;
          dec_o.sub  = 1'b1;
        end
      end
      ece_pkg::F_BOUNCE_IN: begin
        dec_o.opnd = bnc;
        dec_o.b3   = ece_pkg::b_t'(ece_pkg::K_N1);
        dec_o.base = ece_pkg::UNIT - lift;
        dec_o.sub  = 1'b1;
      end
      ece_pkg::F_BOUNCE_OUT: begin
        dec_o.opnd = bnc;
        dec_o.b3   = ece_pkg::b_t'(ece_pkg::K_N1);
        dec_o.base = lift;
      end
      default: begin
        // bounce in-out: result halved in the output rounding
        dec_o.opnd  = bnc;
        dec_o.b3    = ece_pkg::b_t'(ece_pkg::K_N1);
        dec_o.extra = 1'b1;
        if (low_half) begin
          dec_o.base = ece_pkg::UNIT - lift;
          dec_o.sub  = 1'b1;
        end else begin
          dec_o.base = ece_pkg::UNIT + lift;
        end
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: dv/tb_easing_curve_evaluator_unit.sv
`default_nettype none

module tb_easing_curve_evaluator_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import ece_pkg::*;

  // internal fixed point of the predictor
  localparam int     QB      = 28;
  localparam int     SHIFT   = QB - FRAC_BITS;
  localparam longint Q_ONE   = longint'(1) <<< QB;
  localparam longint PH_UNIT = longint'(1) <<< FRAC_BITS;
  localparam longint OUT_MAX = (longint'(1) <<< (OUT_W - 1)) - 1;
  localparam longint OUT_MIN = longint'(1) <<< (OUT_W - 1);
  localparam int     N_ITEMS_RAND = 950;
  localparam int     N_EDGES = 20;

  // constant num/den rounded to nearest in Q.28
  function automatic longint q28_ratio(longint num, longint den);
    return ((num <<< QB) + den / 2) / den;
  endfunction

  localparam longint SLOPE_QUAD  = q28_ratio(25, 16);
  localparam longint TOP_QUAD    = q28_ratio(9, 8);
  localparam longint BEND_QUAD   = q28_ratio(25, 2);
  localparam longint SLOPE_CUBE  = q28_ratio(1953, 1000);
  localparam longint TOP_CUBE    = q28_ratio(19, 16);
  localparam longint BEND_CUBE   = q28_ratio(75, 4);
  localparam longint SLOPE_QUART = q28_ratio(24414, 10000);
  localparam longint GAIN_MID    = q28_ratio(18519, 1000);
  localparam longint C_25        = q28_ratio(25, 1);
  localparam longint C_1P25      = q28_ratio(5, 4);
  localparam longint C_0P9       = q28_ratio(9, 10);
  localparam longint C_0P1       = q28_ratio(1, 10);
  localparam longint C_HALF      = q28_ratio(1, 2);
  localparam longint C_QTR       = q28_ratio(1, 4);
  localparam longint BNC_K       = q28_ratio(121, 16);
  localparam longint BNC_C1      = q28_ratio(6, 11);
  localparam longint BNC_C2      = q28_ratio(9, 11);
  localparam longint BNC_C3      = q28_ratio(21, 22);
  localparam longint BNC_L1      = q28_ratio(3, 4);
  localparam longint BNC_L2      = q28_ratio(15, 16);
  localparam longint BNC_L3      = q28_ratio(63, 64);

  // phases where some curve switches branch, incl. mirrored bounce points, range ends and values above 1.0
  localparam int PHASE_EDGES [N_EDGES] = '{
    0, 2979, 5957, 6554, 8937, 13107, 17873, 20852, 23831, 32768,
    41705, 44684, 47662, 52428, 56600, 59578, 62558, 65536, 65537, 131071
  };

  typedef struct {
    func_t             fn;
    logic [PH_W-1:0]   ph;
    int                gap;
  } stim_t;

  typedef struct {
    func_t             fn;
    logic [PH_W-1:0]   ph;
    logic [OUT_W-1:0]  val;
  } due_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [IN_DW-1:0]  in_tdata = '0;
  func_t             in_tuser = F_QUAD_IN;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OUT_DW-1:0] out_tdata;

  stim_t stim_q [$];
  due_t  eased_due [$];
  int    n_items = 0;
  int    accepted = 0;
  int    results_seen = 0;
  int    errors = 0;
  int    idle_left = 0;
  int    rx_wait = 0;
  int    rx_mode = 0;
  int    rx_cycles = 0;
  logic  hold_rx = 1'b0;

  easing_curve_evaluator_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #1 clk = ~clk;

  // rounded Q.28 product, half away from zero
  function automatic longint mul_q28(longint a, longint b);
    logic [63:0] ma;
    logic [63:0] mb;
    logic [63:0] r;
    ma = (a < 0) ? 64'(-a) : 64'(a);
    mb = (b < 0) ? 64'(-b) : 64'(b);
    r  = (ma * mb + (64'd1 << (QB - 1))) >> QB;
    return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint sq_q28(longint a);
    return mul_q28(a, a);
  endfunction

  function automatic longint cube_q28(longint a);
    return mul_q28(sq_q28(a), a);
  endfunction

  function automatic longint quart_q28(longint a);
    longint s;
    s = sq_q28(a);
    return mul_q28(s, s);
  endfunction

  // bounce ease-out at integer phase u (0..1.0), Q.28 result
  function automatic longint bounce_out_q28(longint u);
    longint t;
    t = u <<< SHIFT;
    if (11 * u < 4 * PH_UNIT)
      return mul_q28(BNC_K, sq_q28(t));
    else if (11 * u < 8 * PH_UNIT)
      return mul_q28(BNC_K, sq_q28(t - BNC_C1)) + BNC_L1;
    else if (11 * u < 10 * PH_UNIT)
      return mul_q28(BNC_K, sq_q28(t - BNC_C2)) + BNC_L2;
    return mul_q28(BNC_K, sq_q28(t - BNC_C3)) + BNC_L3;
  endfunction

  // eased value of one curve at one phase, as the 18-bit output field
  function automatic logic [OUT_W-1:0] eased_of(func_t fn, logic [PH_W-1:0] ph);
    longint      p;
    longint      x;
    longint      r;
    longint      v;
    int          sh;
    logic        neg;
    logic        low_half;
    logic        upto8;
    logic [63:0] m;
    p = (longint'(ph) > PH_UNIT) ? PH_UNIT : longint'(ph);
    x = p <<< SHIFT;
    r = Q_ONE - x;
    low_half = (2 * p < PH_UNIT);
    upto8 = (5 * p <= 4 * PH_UNIT);
    sh = SHIFT;
    case (fn)
      F_QUAD_IN:     v = sq_q28(x);
      F_QUAD_OUT:    v = Q_ONE - sq_q28(r);
      F_QUAD_INOUT:  v = low_half ? 2 * sq_q28(x) : Q_ONE - 2 * sq_q28(r);
      F_QUAD_PUMP:   v = upto8 ? mul_q28(SLOPE_QUAD, sq_q28(x))
                               : TOP_QUAD - mul_q28(BEND_QUAD, sq_q28(C_0P9 - x));
      F_CUBE_IN:     v = cube_q28(x);
      F_CUBE_OUT:    v = Q_ONE - cube_q28(r);
      F_CUBE_INOUT:  v = low_half ? 4 * cube_q28(x) : Q_ONE - 4 * cube_q28(r);
      F_CUBE_PUMP:   v = upto8 ? mul_q28(SLOPE_CUBE, cube_q28(x))
                               : TOP_CUBE - mul_q28(BEND_CUBE, sq_q28(C_0P9 - x));
      F_CUBE_PUMP_INOUT: begin
        if (5 * p <= PH_UNIT)
          v = mul_q28(C_25, sq_q28(C_0P1 - x)) - C_QTR;
        else if (5 * p >= 4 * PH_UNIT)
          v = C_1P25 - mul_q28(C_25, sq_q28(C_0P9 - x));
        else
          v = C_HALF - mul_q28(GAIN_MID, cube_q28(C_HALF - x));
      end
      F_QUART_IN:    v = quart_q28(x);
      F_QUART_OUT:   v = Q_ONE - quart_q28(r);
      F_QUART_INOUT: v = low_half ? 8 * quart_q28(x) : Q_ONE - 8 * quart_q28(r);
      F_QUART_PUMP:  v = upto8 ? mul_q28(SLOPE_QUART, quart_q28(x))
                               : C_1P25 - mul_q28(C_25, sq_q28(C_0P9 - x));
      F_BOUNCE_IN:   v = Q_ONE - bounce_out_q28(PH_UNIT - p);
      F_BOUNCE_OUT:  v = bounce_out_q28(p);
      default: begin
        // bounce in-out: sum kept at double scale, halved in the final rounding
        sh = SHIFT + 1;
        v = low_half ? Q_ONE - bounce_out_q28(PH_UNIT - 2 * p)
                     : Q_ONE + bounce_out_q28(2 * p - PH_UNIT);
      end
    endcase
    // round to nearest, half away from zero, then saturate
    neg = (v < 0);
    m = neg ? 64'(-v) : 64'(v);
    m = (m + (64'd1 << (sh - 1))) >> sh;
    if (neg) begin
      if (m > 64'(OUT_MIN)) m = 64'(OUT_MIN);
      return OUT_W'(64'd0 - m);
    end
    if (m > 64'(OUT_MAX)) m = 64'(OUT_MAX);
    return OUT_W'(m);
  endfunction

  // idle length: mode 0 none, 1 light, 2 heavy with a few long gaps
  function automatic int gap_len(int mode);
    int r;
    r = $urandom_range(0, 99);
    if (mode == 0) return 0;
    if (mode == 1) begin
      if (r < 75) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(4, 12);
    end
    if (r < 40) return 0;
    if (r < 80) return $urandom_range(1, 4);
    if (r < 96) return $urandom_range(5, 15);
    return $urandom_range(20, 60);
  endfunction

  // mostly in range, some near branch points, some above 1.0
  function automatic int rand_phase();
    int r;
    int p;
    r = $urandom_range(0, 99);
    if (r < 10) return $urandom_range(65537, 131071);
    if (r < 30) begin
      p = PHASE_EDGES[$urandom_range(0, N_EDGES - 1)] + $urandom_range(0, 6) - 3;
      if (p < 0) p = 0;
      if (p > 131071) p = 131071;
      return p;
    end
    return $urandom_range(0, 65536);
  endfunction

  task automatic add_item(func_t fn, int ph, int gap);
    stim_t it;
    it.fn = fn;
    it.ph = PH_W'(ph);
    it.gap = gap;
    stim_q.push_back(it);
    n_items++;
  endtask

  task automatic note_error(string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endtask

  // input driver: one item per transfer, idles after each item as queued
  always @(posedge clk) begin : drive
    stim_t cur;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      idle_left <= 0;
    end else if (!(in_tvalid && !in_tready)) begin
      if (in_tvalid) begin
        eased_due.push_back('{fn: in_tuser, ph: in_tdata[PH_W-1:0],
                              val: eased_of(in_tuser, in_tdata[PH_W-1:0])});
        accepted++;
      end
      if (idle_left > 0) begin
        idle_left <= idle_left - 1;
        in_tvalid <= 1'b0;
      end else if (stim_q.size() > 0) begin
        cur = stim_q.pop_front();
        in_tvalid <= 1'b1;
        in_tdata <= IN_DW'(cur.ph);
        in_tuser <= cur.fn;
        idle_left <= cur.gap;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result monitor and output backpressure
  always @(posedge clk) begin : watch
    due_t want;
    int   n;
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_wait <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (eased_due.size() == 0) begin
          note_error($sformatf("unexpected result %0d",
                               $signed(out_tdata[OUT_W-1:0])));
        end else begin
          want = eased_due.pop_front();
          if (out_tdata[OUT_W-1:0] !== want.val)
            note_error($sformatf("mismatch %s phase %0d: expected %0d got %0d",
                                 want.fn.name(), want.ph, $signed(want.val),
                                 $signed(out_tdata[OUT_W-1:0])));
        end
      end
      if (rx_cycles % 64 == 0) rx_mode = $urandom_range(0, 2);
      rx_cycles++;
      if (rx_wait > 0) begin
        rx_wait <= rx_wait - 1;
        out_tready <= 1'b0;
      end else begin
        n = gap_len(rx_mode);
        rx_wait <= (n == 0) ? 0 : n - 1;
        out_tready <= (n == 0) && !hold_rx;
      end
    end
  end

  // long receiver hold-off so the pipeline fills and blocks its input
  initial begin
    wait (results_seen >= 300);
    @(posedge clk);
    hold_rx <= 1'b1;
    repeat (250) @(posedge clk);
    hold_rx <= 1'b0;
  end

  initial begin
    #1_000_000;
    $display("[easing_curve_evaluator_unit] ERROR");
    $finish;
  end

  // reset, stimulus and end of run
  initial begin
    int mode;
    // directed: every curve, range ends, saturation and branch points
    add_item(F_QUAD_IN, 0, 0);
    add_item(F_QUAD_OUT, 65536, 0);
    add_item(F_QUAD_INOUT, 32767, 1);
    add_item(F_QUAD_PUMP, 52428, 0);
    add_item(F_CUBE_IN, 131071, 0);
    add_item(F_CUBE_OUT, 1, 2);
    add_item(F_CUBE_INOUT, 32768, 0);
    add_item(F_CUBE_PUMP, 52429, 0);
    add_item(F_CUBE_PUMP_INOUT, 13107, 0);
    add_item(F_CUBE_PUMP_INOUT, 13108, 0);
    add_item(F_CUBE_PUMP_INOUT, 52429, 3);
    add_item(F_QUART_IN, 65535, 0);
    add_item(F_QUART_OUT, 0, 0);
    add_item(F_QUART_INOUT, 32767, 0);
    add_item(F_QUART_PUMP, 52428, 0);
    add_item(F_QUART_PUMP, 65537, 1);
    add_item(F_BOUNCE_IN, 0, 0);
    add_item(F_BOUNCE_OUT, 23831, 0);
    add_item(F_BOUNCE_OUT, 23832, 0);
    add_item(F_BOUNCE_OUT, 47663, 0);
    add_item(F_BOUNCE_OUT, 59578, 0);
    add_item(F_BOUNCE_OUT, 59579, 0);
    add_item(F_BOUNCE_INOUT, 32768, 0);
    add_item(F_BOUNCE_INOUT, 0, 0);
    add_item(F_BOUNCE_INOUT, 65536, 4);

    // random part in stretches, each with its own sender idle mode
    for (int i = 0; i < N_ITEMS_RAND; i++) begin
      if (i % 50 == 0) mode = (i == 0) ? 0 : $urandom_range(0, 2);
      add_item(func_t'($urandom_range(0, 15)), rand_phase(), gap_len(mode));
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (accepted < n_items) @(posedge clk);
    while (eased_due.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0)
      $display("[easing_curve_evaluator_unit] OK");
    else
      $display("[easing_curve_evaluator_unit] ERROR");
    $finish;
  end

endmodule

`default_nettype wire
